[hw/rtl/bfs_pkg.sv]
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, constants and SHA-256 helper functions for the bloom filter.
// ----------------------------------------------------------------------------
package bfs_pkg;

	// default filter size and register reset values
	localparam int unsigned DEF_MAX_BITS = 65536;
	localparam logic [4:0]  NH_RST       = 5'd3;
	localparam logic [16:0] BC_RST       = 17'd65536;

	// register index, taken from paddr[2]
	localparam logic REG_NUM_HASHES = 1'b0;
	localparam logic REG_BIT_COUNT  = 1'b1;

	// widest chunk: seven bytes
	localparam int unsigned CHUNK_W = 56;

	// byte positions inside one 64-byte block, last round index and pad marker
	localparam logic [5:0] POS_LAST   = 6'd63;
	localparam logic [5:0] POS_LENGTH = 6'd56;
	localparam logic [5:0] RND_LAST   = 6'd63;
	localparam logic [7:0] PAD_MARK   = 8'h80;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RINIT,
		ST_ROUND,
		ST_HADD,
		ST_XINIT,
		ST_LOAD,
		ST_MOD,
		ST_MEM,
		ST_CHK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_ABSORB,
		PH_PAD1,
		PH_PAD2
	} phase_t;

	// how block words are formed during a compression
	typedef enum logic [1:0] {
		PAD_NONE,
		PAD_MARK_BLK,
		PAD_LEN_BLK
	} pad_t;

	typedef struct packed {
		logic       byte_wr;
		logic       rnd_init;
		logic       rnd_step;
		logic       hash_add;
		pad_t       pad;
		logic [5:0] rnd;
		logic       hash_rst;
		logic       idx_init;
		logic       chunk_load;
		logic       mod_step;
		logic       mem_wr;
		logic       mem_rd;
		logic       check;
		logic       clr_wr;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       tail_long;
		logic       act;
		logic [2:0] clen;
		logic       clr_last;
	} sts_t;

	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

	// bytes per chunk: min(32 / n, 7), zero for no hashes
	function automatic logic [2:0] chunk_len(input logic [4:0] n);
		logic [2:0] r;
		case (n) inside
			5'd0:             r = 3'd0;
			[5'd1:5'd4]:      r = 3'd7;
			5'd5:             r = 3'd6;
			5'd6:             r = 3'd5;
			[5'd7:5'd8]:      r = 3'd4;
			[5'd9:5'd10]:     r = 3'd3;
			[5'd11:5'd16]:    r = 3'd2;
			default:          r = 3'd1;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/bfs_ctrl.sv]
// ----------------------------------------------------------------------------
// bfs_ctrl
// Sequencer: byte intake, compression rounds, padding blocks, index loop.
// ----------------------------------------------------------------------------
module bfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          key_last,
	input  logic [4:0]    num_hashes,
	input  bfs_pkg::sts_t sts,
	output bfs_pkg::cmd_t cmd,
	output logic          busy
);
	import bfs_pkg::*;

	state_t     state_q, state_nxt;
	phase_t     phase_q;
	logic       fin_q;
	logic [5:0] rnd_q;
	logic [5:0] step_q;
	logic [4:0] hcnt_q;
	logic       hash_last;
	logic       mod_last;

	assign hash_last = hcnt_q == (num_hashes - 5'd1);
	assign mod_last  = step_q == ({sts.clen, 3'b000} - 6'd1);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start && ((sts.pos == POS_LAST) || key_last)) state_nxt = ST_RINIT;
			end
			ST_RINIT: state_nxt = ST_ROUND;
			ST_ROUND: begin
				if (rnd_q == RND_LAST) state_nxt = ST_HADD;
			end
			ST_HADD: begin
				case (phase_q)
					PH_ABSORB: state_nxt = fin_q ? ST_RINIT : ST_IDLE;
					PH_PAD1:   state_nxt = sts.tail_long ? ST_RINIT : ST_XINIT;
					default:   state_nxt = ST_XINIT;
				endcase
			end
			ST_XINIT: state_nxt = (num_hashes == 5'd0) ? ST_DONE : ST_LOAD;
			ST_LOAD:  state_nxt = ST_MOD;
			ST_MOD: begin
				if (mod_last) state_nxt = ST_MEM;
			end
			ST_MEM: begin
				if (sts.act) state_nxt = ST_CHK;
				else         state_nxt = hash_last ? ST_DONE : ST_LOAD;
			end
			ST_CHK:  state_nxt = hash_last ? ST_DONE : ST_LOAD;
			ST_DONE: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd     = '0;
		cmd.rnd = rnd_q;
		busy    = state_q != ST_IDLE;
		case (state_q)
			ST_CLEAR: cmd.clr_wr   = 1'b1;
			ST_IDLE:  cmd.byte_wr  = start;
			ST_RINIT: cmd.rnd_init = 1'b1;
			ST_ROUND: begin
				cmd.rnd_step = 1'b1;
				case (phase_q)
					PH_ABSORB: cmd.pad = PAD_NONE;
					PH_PAD1:   cmd.pad = PAD_MARK_BLK;
					default:   cmd.pad = PAD_LEN_BLK;
				endcase
			end
			ST_HADD:  cmd.hash_add   = 1'b1;
			ST_XINIT: cmd.idx_init   = 1'b1;
			ST_LOAD:  cmd.chunk_load = 1'b1;
			ST_MOD:   cmd.mod_step   = 1'b1;
			ST_MEM: begin
				cmd.mem_rd = sts.act;
				cmd.mem_wr = !sts.act;
			end
			ST_CHK: cmd.check = 1'b1;
			ST_DONE: begin
				cmd.finish   = 1'b1;
				cmd.hash_rst = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= PH_ABSORB;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
			step_q  <= '0;
			hcnt_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && start) begin
				fin_q   <= key_last;
				phase_q <= (sts.pos == POS_LAST) ? PH_ABSORB : PH_PAD1;
			end
			if (state_q == ST_HADD) begin
				if (phase_q == PH_ABSORB)    phase_q <= PH_PAD1;
				else if (phase_q == PH_PAD1) phase_q <= PH_PAD2;
			end
			if (state_q == ST_RINIT) rnd_q <= '0;
			else if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_LOAD) step_q <= '0;
			else if (state_q == ST_MOD) step_q <= step_q + 6'd1;
			if (state_q == ST_XINIT) hcnt_q <= '0;
			else if ((state_q == ST_MEM && !sts.act) || state_q == ST_CHK)
				hcnt_q <= hcnt_q + 5'd1;
		end
	end

endmodule

[hw/rtl/bfs_dp.sv]
// ----------------------------------------------------------------------------
// bfs_dp
// Datapath: block buffer, SHA-256 round engine, modulo unit, filter memory.
// ----------------------------------------------------------------------------
module bfs_dp #(
	parameter int unsigned MAX_BITS = bfs_pkg::DEF_MAX_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bfs_pkg::cmd_t cmd,
	input  logic          action,
	input  logic [7:0]    key_byte,
	input  logic [4:0]    num_hashes,
	input  logic [16:0]   bit_count,
	output bfs_pkg::sts_t sts,
	output logic          done,
	output logic          was_query,
	output logic          may_contain
);
	import bfs_pkg::*;

	localparam int unsigned MW = $clog2(MAX_BITS + 1);
	localparam int unsigned AW = $clog2(MAX_BITS);

	logic [31:0]        buf_q [16];
	logic [31:0]        hash_q [8];
	logic [31:0]        v_q [8];
	logic [31:0]        w_q [16];
	logic [60:0]        len_q;
	logic               act_q;
	logic               in_key_q;
	logic [AW-1:0]      clr_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [MW-1:0]      rem_q;
	logic [4:0]         pos_q;
	logic               all_q;
	logic               rd_q;
	logic               done_q;
	logic               wq_q;
	logic               mc_q;
	logic               fmem [MAX_BITS];

	logic [5:0]         p;
	logic [2:0]         clen;
	logic [63:0]        len_bits;
	logic [31:0]        w_pad;
	logic [31:0]        w_t;
	logic [31:0]        t1;
	logic [31:0]        t2;
	logic [255:0]       dig;
	logic [CHUNK_W-1:0] aligned;
	logic [MW-1:0]      modulus;
	logic [31:0]        mod32;
	logic [MW:0]        rx;
	logic [AW-1:0]      idx;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;

	assign p        = len_q[5:0];
	assign clen     = chunk_len(num_hashes);
	assign len_bits = {len_q, 3'b000};
	assign idx      = rem_q[AW-1:0];

	assign sts.pos       = p;
	assign sts.tail_long = p >= POS_LENGTH;
	assign sts.act       = act_q;
	assign sts.clen      = clen;
	assign sts.clr_last  = clr_q == AW'(MAX_BITS - 1);

	// block word for the current round, padding applied
	always_comb begin
		logic [31:0] raw;
		logic [5:0]  j;
		logic [7:0]  bv;
		raw = buf_q[cmd.rnd[3:0]];
		for (int k = 0; k < 4; k++) begin
			j  = {cmd.rnd[3:0], 2'(k)};
			bv = raw[8*(3-k) +: 8];
			if (cmd.pad == PAD_MARK_BLK) begin
				if (j == p) bv = PAD_MARK;
				else if (j > p) bv = 8'h00;
				if (p < POS_LENGTH && j >= POS_LENGTH)
					bv = len_bits[{~j[2:0], 3'b000} +: 8];
			end else if (cmd.pad == PAD_LEN_BLK) begin
				bv = (j >= POS_LENGTH) ? len_bits[{~j[2:0], 3'b000} +: 8] : 8'h00;
			end
			w_pad[8*(3-k) +: 8] = bv;
		end
	end

	// message schedule and round function
	always_comb begin
		if (cmd.rnd < 6'd16) w_t = w_pad;
		else w_t = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
		t1 = v_q[7] + bsig1(v_q[4]) + ch(v_q[4], v_q[5], v_q[6]) + K_TAB[cmd.rnd] + w_t;
		t2 = bsig0(v_q[0]) + maj(v_q[0], v_q[1], v_q[2]);
	end

	// digest bytes, chunk left-aligned for msb-first reduction
	always_comb begin
		logic [4:0] bi;
		logic [2:0] sh;
		dig = {hash_q[0], hash_q[1], hash_q[2], hash_q[3],
			hash_q[4], hash_q[5], hash_q[6], hash_q[7]};
		aligned = '0;
		for (int b = 0; b < 7; b++) begin
			bi = pos_q + 5'(b);
			sh = 3'd7 - clen + 3'(b);
			if (3'(b) < clen) aligned[{sh, 3'b000} +: 8] = dig[{~bi, 3'b000} +: 8];
		end
	end

	// modulus clamp and one restoring step
	always_comb begin
		if (bit_count == 17'd0) mod32 = 32'd1;
		else if (32'(bit_count) > MAX_BITS) mod32 = MAX_BITS;
		else mod32 = 32'(bit_count);
		modulus = MW'(mod32);
		rx = {rem_q, chunk_q[CHUNK_W-1]};
	end

	assign mem_we = cmd.clr_wr || cmd.mem_wr;
	assign mem_wa = cmd.clr_wr ? clr_q : idx;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q   <= IV_TAB;
			len_q    <= '0;
			act_q    <= 1'b0;
			in_key_q <= 1'b0;
			clr_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.byte_wr) begin
				len_q <= len_q + 61'd1;
				if (!in_key_q) begin
					act_q    <= action;
					in_key_q <= 1'b1;
				end
			end
			if (cmd.hash_add) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
			end
			if (cmd.hash_rst) begin
				hash_q   <= IV_TAB;
				len_q    <= '0;
				in_key_q <= 1'b0;
			end
			if (cmd.clr_wr) clr_q <= clr_q + AW'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.byte_wr) buf_q[len_q[5:2]][{~len_q[1:0], 3'b000} +: 8] <= key_byte;
		if (cmd.rnd_init) v_q <= hash_q;
		if (cmd.rnd_step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_t;
		end
		if (cmd.idx_init) begin
			pos_q <= '0;
			all_q <= 1'b1;
		end
		if (cmd.chunk_load) begin
			chunk_q <= aligned;
			rem_q   <= '0;
			pos_q   <= pos_q + 5'(clen);
		end
		if (cmd.mod_step) begin
			chunk_q <= {chunk_q[CHUNK_W-2:0], 1'b0};
			if (rx >= {1'b0, modulus}) rem_q <= MW'(rx - {1'b0, modulus});
			else rem_q <= MW'(rx);
		end
		if (cmd.check) all_q <= all_q & rd_q;
		if (cmd.finish) begin
			wq_q <= act_q;
			mc_q <= act_q & all_q;
		end
	end

	// filter bit store
	always_ff @(posedge clk) begin
		if (mem_we) fmem[mem_wa] <= !cmd.clr_wr;
		if (cmd.mem_rd) rd_q <= fmem[idx];
	end

	assign done        = done_q;
	assign was_query   = wq_q;
	assign may_contain = mc_q;

endmodule

[hw/rtl/bloom_filter_sha256.sv]
// ----------------------------------------------------------------------------
// bloom_filter_sha256
// Bloom filter over byte-serial keys, indexed by chunks of a SHA-256 digest.
// ----------------------------------------------------------------------------
// A key arrives one byte per request: start with action, key_byte, key_last,
// taken when busy is low. action counts on the first byte of a key only.
// Bytes are taken one per cycle while idle; the 64th byte of a block starts
// a compression (load, 64 rounds, digest add) on one shared round engine.
// After the last byte, padding takes one compression, or two when the tail
// of the key leaves less than 9 free bytes in the block. Per hash, the index
// loop loads a digest chunk, reduces it bit-serially, and writes the filter
// bit on insert, or reads and checks it on query. A one-cycle done strobe
// carries was_query and may_contain; the receiver cannot stall, and no new
// byte is taken until the result is out. After reset busy stays high while
// the filter memory is swept to zero, one bit per cycle. Registers:
// num_hashes at 0x0 (reset 3), bit_count at 0x4 (reset 65536). The user
// writes them over the APB port when idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module bloom_filter_sha256 #(
	parameter int unsigned MAX_BITS = bfs_pkg::DEF_MAX_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	output logic        done,
	output logic        was_query,
	output logic        may_contain,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bfs_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [4:0]  nh_q;
	logic [16:0] bc_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nh_q <= NH_RST;
			bc_q <= BC_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_NUM_HASHES) nh_q <= pwdata[4:0];
			else bc_q <= pwdata[16:0];
		end
	end

	// register read
	always_comb begin
		if (paddr[2] == REG_BIT_COUNT) prdata = {15'd0, bc_q};
		else prdata = {27'd0, nh_q};
	end

	bfs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.key_last   (key_last),
		.num_hashes (nh_q),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	bfs_dp #(
		.MAX_BITS (MAX_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (action),
		.key_byte    (key_byte),
		.num_hashes  (nh_q),
		.bit_count   (bc_q),
		.sts         (sts),
		.done        (done),
		.was_query   (was_query),
		.may_contain (may_contain)
	);

`ifndef ASSERT_OFF
	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without busy period");

	// an insert never reports a hit
	a_hit_is_query: assert property (@(posedge clk) disable iff (!arst_n)
		(done && may_contain) |-> was_query) else $error("hit on insert");

	// result strobe is a single pulse and the block is then idle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done) else $error("result strobe too long");
`endif

endmodule

[tb/sv/bloom_filter_sha256_chk.sv]
// ----------------------------------------------------------------------------
// bloom_filter_sha256_chk
// Watches the key byte, result and register channels of the bloom filter,
// hashes each finished key with its own SHA-256 model, keeps a shadow filter
// and compares every result strobe against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module bloom_filter_sha256_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        action,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic        done,
	input  logic        was_query,
	input  logic        may_contain,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FILT_BITS = 65536;

	typedef struct packed {
		logic q;
		logic hit;
	} verdict_t;

	localparam logic [31:0] RND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] START_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	verdict_t          verdicts [$];
	bit                filt [FILT_BITS];
	logic [31:0]       hv [8];
	logic [7:0]        blk [64];
	longint unsigned   klen;
	logic              kact;
	logic              inkey;
	logic [4:0]        nh_reg;
	logic [16:0]       bc_reg;
	int                err_cnt;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one SHA-256 block over blk into hv
	task automatic sha_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ RND_K[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) ^ 32'h0;
			t2 = t2 + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
		hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
	endtask

	// pad, hash and run the index loop for the finished key
	task automatic finish_key();
		logic [7:0]      dig [32];
		logic [63:0]     lbits;
		int unsigned     pos, modv, clen, p;
		logic [63:0]     chunk, idx;
		logic            all_set;
		verdict_t        nv;
		pos = klen[5:0];
		lbits = klen << 3;
		blk[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				blk[pos] = 8'h00;
				pos++;
			end
			sha_block();
			pos = 0;
		end
		while (pos < 56) begin
			blk[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			blk[56+i] = lbits[63-8*i -: 8];
		sha_block();
		for (int i = 0; i < 32; i++)
			dig[i] = hv[i/4][31-8*(i%4) -: 8];
		modv = (bc_reg == 0) ? 1 : bc_reg;
		if (modv > FILT_BITS) modv = FILT_BITS;
		clen = (nh_reg != 0) ? 32 / nh_reg : 0;
		if (clen > 7) clen = 7;
		p = 0;
		all_set = 1'b1;
		for (int k = 0; k < nh_reg; k++) begin
			chunk = '0;
			for (int j = 0; j < clen; j++) begin
				chunk |= 64'(dig[p % 32]) << (8 * j);
				p++;
			end
			idx = chunk % modv;
			if (!kact) filt[idx] = 1'b1;
			else if (!filt[idx]) all_set = 1'b0;
		end
		// queue the verdict behind any still waiting
		nv.q = kact;
		nv.hit = kact & all_set;
		verdicts = {verdicts, nv};
		for (int i = 0; i < 8; i++) hv[i] = START_H[i];
		klen = 0;
		inkey = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		logic [31:0] rd_exp;
		if (!arst_n) begin
			for (int i = 0; i < FILT_BITS; i++) filt[i] = 1'b0;
			for (int i = 0; i < 8; i++) hv[i] = START_H[i];
			for (int i = 0; i < 64; i++) blk[i] = 8'h00;
			klen = 0;
			kact = 1'b0;
			inkey = 1'b0;
			nh_reg = bfs_pkg::NH_RST;
			bc_reg = bfs_pkg::BC_RST;
			verdicts.delete();
			err_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			// result strobe against oldest verdict
			if (done) begin
				if (verdicts.size() == 0) begin
					$error("result strobe with no request waiting");
					err_cnt++;
				end else begin
					v = verdicts.pop_front();
					if (was_query !== v.q) begin
						$error("was_query expected %0d actual %0d", v.q, was_query);
						err_cnt++;
					end
					if (may_contain !== v.hit) begin
						$error("may_contain expected %0d actual %0d", v.hit, may_contain);
						err_cnt++;
					end
				end
			end
			// register port
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == bfs_pkg::REG_BIT_COUNT) bc_reg = pwdata[16:0];
					else nh_reg = pwdata[4:0];
				end else begin
					rd_exp = (paddr[2] == bfs_pkg::REG_BIT_COUNT) ? 32'(bc_reg) : 32'(nh_reg);
					if (prdata !== rd_exp) begin
						$error("prdata expected %0h actual %0h", rd_exp, prdata);
						err_cnt++;
					end
				end
			end
			// accepted key byte
			if (start && !busy) begin
				if (!inkey) begin
					kact = action;
					inkey = 1'b1;
				end
				blk[klen[5:0]] = key_byte;
				klen++;
				if (klen[5:0] == 6'd0) sha_block();
				if (key_last) finish_key();
			end
			errors <= err_cnt;
			pending <= verdicts.size();
		end
	end

endmodule

[tb/sv/bloom_filter_sha256_tb.sv]
// ----------------------------------------------------------------------------
// bloom_filter_sha256_tb
// Drives byte-serial insert and query keys with random gaps and register
// settings into the bloom filter; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module bloom_filter_sha256_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] NH_ADDR    = 3'd0;
	localparam logic [2:0] BC_ADDR    = 3'd4;
	localparam int         IDLE_LIMIT = 300000;
	localparam int         BYTE_GOAL  = 1350;
	localparam logic       ACT_INSERT = 1'b0;
	localparam logic       ACT_QUERY  = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [7:0]  key_byte;
	logic        key_last;
	logic        done;
	logic        was_query;
	logic        may_contain;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          idle_cnt;
	int          n_bytes;
	int          n_keys;
	int          n_settings;

	bloom_filter_sha256 dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.key_byte(key_byte), .key_last(key_last), .done(done), .was_query(was_query),
		.may_contain(may_contain), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bloom_filter_sha256_chk chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.key_byte(key_byte), .key_last(key_last), .done(done), .was_query(was_query),
		.may_contain(may_contain), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("bloom_filter_sha256_tb: errors");
			$finish;
		end
	end

	task automatic gap(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 120);
	endfunction

	// one key byte request, held until taken
	task automatic send_byte(input logic act, input logic [7:0] b, input logic last);
		@(negedge clk);
		start <= 1'b1;
		action <= act;
		key_byte <= b;
		key_last <= last;
		do @(posedge clk); while (busy);
		n_bytes++;
	endtask

	task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		start <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// drain every outstanding result before touching registers
	task automatic drain();
		gap(1);
		do @(posedge clk); while (pending != 0 || busy);
		repeat (400) @(posedge clk);
	endtask

	// key from a small pool so queries can hit earlier inserts
	function automatic logic [7:0] pool_byte(input int s, input int j);
		return 8'((s * 73 + j * 29 + 5) ^ (j >> 3));
	endfunction

	function automatic int pool_len(input int s);
		case (s)
			12: return 55;
			13: return 56;
			14: return 63;
			15: return 64;
			default: return (s * 7) % 13 + 1;
		endcase
	endfunction

	task automatic send_key(input logic act, input int len, input int s, input bit pooled,
			input bit gaps);
		logic [7:0] b;
		for (int j = 0; j < len; j++) begin
			b = pooled ? pool_byte(s, j) : 8'($urandom);
			send_byte((j == 0) ? act : logic'($urandom), b, j == len - 1);
			if (gaps) gap(rand_gap());
		end
		n_keys++;
	endtask

	task automatic set_regs(input logic [31:0] nh, input logic [31:0] bc);
		drain();
		apb_xfer(1'b1, NH_ADDR, nh);
		apb_xfer(1'b1, BC_ADDR, bc);
		apb_xfer(1'b0, NH_ADDR, '0);
		apb_xfer(1'b0, BC_ADDR, '0);
		n_settings++;
	endtask

	function automatic logic [31:0] pick_nh();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 31;
			3: return $urandom_range(2, 4);
			4: return $urandom_range(5, 8);
			5: return $urandom_range(9, 16);
			6: return $urandom_range(17, 30);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	function automatic logic [31:0] pick_bc();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 8;
			2: return 65536;
			3: return 32'h1ffff;
			4: return $urandom_range(65537, 131071);
			5: return $urandom_range(9, 64);
			6: return $urandom;
			default: return $urandom_range(8, 65535);
		endcase
	endfunction

	initial begin
		int s;
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		key_byte = 8'h00;
		key_last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_cnt = 0;
		n_bytes = 0;
		n_keys = 0;
		n_settings = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset values, byte extremes, both actions
		drain();
		apb_xfer(1'b0, NH_ADDR, '0);
		apb_xfer(1'b0, BC_ADDR, '0);
		send_byte(ACT_INSERT, 8'h00, 1'b1);
		send_byte(ACT_QUERY, 8'h00, 1'b1);
		send_byte(ACT_QUERY, 8'hff, 1'b1);
		send_byte(ACT_INSERT, 8'hff, 1'b0);
		send_byte(ACT_QUERY, 8'h00, 1'b1);
		// zero hashes: insert is a no-op, query answers one
		set_regs(0, 65536);
		send_byte(ACT_INSERT, 8'h5a, 1'b1);
		send_byte(ACT_QUERY, 8'ha5, 1'b1);
		// zero modulus acts as one, so every query hits after one insert
		set_regs(31, 0);
		send_byte(ACT_INSERT, 8'h11, 1'b1);
		send_byte(ACT_QUERY, 8'h22, 1'b1);
		// oversized modulus saturates
		set_regs(1, 32'h1ffff);
		send_byte(ACT_INSERT, 8'h33, 1'b1);
		send_byte(ACT_QUERY, 8'h33, 1'b1);
		// register write between bytes of a key, values at the last byte rule
		set_regs(3, 8);
		send_byte(ACT_INSERT, 8'h44, 1'b0);
		gap(1);
		do @(posedge clk); while (busy);
		apb_xfer(1'b1, NH_ADDR, 2);
		apb_xfer(1'b1, BC_ADDR, 13);
		send_byte(ACT_QUERY, 8'h55, 1'b0);
		send_byte(ACT_QUERY, 8'h66, 1'b1);
		send_byte(ACT_QUERY, 8'h44, 1'b0);
		send_byte(ACT_INSERT, 8'h55, 1'b0);
		send_byte(ACT_INSERT, 8'h66, 1'b1);
		set_regs(3, 65536);

		// random: mostly pooled keys, some fresh random ones, long keys now and then
		while (n_bytes < BYTE_GOAL) begin
			if ($urandom_range(0, 29) == 0) set_regs(pick_nh(), pick_bc());
			if ($urandom_range(0, 99) < 60) begin
				s = $urandom_range(0, 15);
				send_key(logic'($urandom), pool_len(s), s, 1'b1, $urandom_range(0, 3) != 0);
			end else if ($urandom_range(0, 9) == 0) begin
				send_key(logic'($urandom), $urandom_range(50, 140), 0, 1'b0, 1'b1);
			end else begin
				send_key(logic'($urandom), $urandom_range(1, 12), 0, 1'b0,
					$urandom_range(0, 3) != 0);
			end
		end

		gap(1);
		do @(posedge clk); while (pending != 0);
		repeat (600) @(posedge clk);
		$display("covered %0d key bytes in %0d keys over %0d register settings",
			n_bytes, n_keys, n_settings);
		if (errors == 0) begin
			$display("bloom_filter_sha256_tb: clean");
		end else begin
			$display("bloom_filter_sha256_tb: errors");
		end
		$finish;
	end

endmodule
